[rtl/wfpa_pkg.sv]
// wfpa_pkg: shared types, constants and codes for the worst-fit paged allocator
// used by the controller, the datapath and the top level; depends on nothing

package wfpa_pkg;

    localparam int PAGE_BYTES_DEF  = 4096;
    localparam int GRAIN_BYTES_DEF = 256;
    localparam int PAGES_DEF       = 4;

    localparam int SIZE_W = 13;
    localparam int ADDR_W = 14;
    localparam int STAT_W = 2;

    typedef enum logic [1:0] {
        ST_OK      = 2'd0,
        ST_NOSPACE = 2'd1,
        ST_BADSIZE = 2'd2,
        ST_BADFREE = 2'd3
    } status_t;

    typedef enum logic [3:0] {
        S_IDLE,
        S_CHECK,
        S_OPEN,
        S_SCAN,
        S_EVAL,
        S_CARVE,
        S_NEXTPG,
        S_FREE_RD,
        S_FREE_WR,
        S_FREE_CLR,
        S_DONE,
        S_FAIL
    } state_t;

    // commands from the controller to the datapath
    typedef struct packed {
        logic latch;      // capture request
        logic open_page;  // mark page used_reg fully free, count it open
        logic scan_clr;   // reset run search at granule 0
        logic scan_step;  // examine one granule
        logic carve_clr;  // start carve at best start
        logic carve_step; // clear one granule
        logic len_wr;     // record allocation length
        logic next_page;  // advance page under search
        logic len_rd;     // read length store at freed granule
        logic free_start; // begin releasing granules
        logic free_step;  // release one granule
        logic len_clr;    // clear length entry
        logic emit_ok;    // present granted result
        logic emit_fail;  // present failure result
    } cmd_t;

    // status from the datapath to the controller
    typedef struct packed {
        logic is_free;     // request is a free
        logic bad_size;    // size is zero or not granule aligned
        logic pg_open;     // page under search is open
        logic pg_can_open; // another page may still be opened
        logic scan_last;   // scanning the last granule
        logic fits;        // best run covers the request
        logic carve_last;  // last granule of the carve
        logic free_bad;    // free address is off an open page or off a granule boundary
        logic len_zero;    // length read is zero or not valid
        logic free_last;   // last granule of the release
    } stat_t;

endpackage

[rtl/wfpa_ctrl.sv]
// wfpa_ctrl: request sequencer of the worst-fit paged allocator
// depends on wfpa_pkg

module wfpa_ctrl
    import wfpa_pkg::*;
(
    input  logic   clk,
    input  logic   rst_n,
    input  logic   start,
    output logic   busy,
    output cmd_t   cmd,
    input  stat_t  st
);

    state_t state_reg, state_next;

    // state register
    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
            state_reg <= S_IDLE;
        else
            state_reg <= state_next;
    end

    // next state
    always_comb
    begin
        state_next = state_reg;
        case (state_reg)
            S_IDLE:
                if (start)
                    state_next = S_CHECK;
            S_CHECK:
                if (st.is_free)
                    state_next = st.free_bad ? S_FAIL : S_FREE_RD;
                else if (st.bad_size)
                    state_next = S_FAIL;
                else if (st.pg_open)
                    state_next = S_SCAN;
                else if (st.pg_can_open)
                    state_next = S_OPEN;
                else
                    state_next = S_FAIL;
            S_OPEN:
                state_next = S_SCAN;
            S_SCAN:
                if (st.scan_last)
                    state_next = S_EVAL;
            S_EVAL:
                if (st.fits)
                    state_next = S_CARVE;
                else
                    state_next = S_NEXTPG;
            S_NEXTPG:
                if (st.pg_open)
                    state_next = S_SCAN;
                else if (st.pg_can_open)
                    state_next = S_OPEN;
                else
                    state_next = S_FAIL;
            S_CARVE:
                if (st.carve_last)
                    state_next = S_DONE;
            S_FREE_RD:
                state_next = S_FREE_WR;
            S_FREE_WR:
                state_next = st.len_zero ? S_FAIL : S_FREE_CLR;
            S_FREE_CLR:
                if (st.free_last)
                    state_next = S_DONE;
            S_DONE:
                state_next = S_IDLE;
            S_FAIL:
                state_next = S_IDLE;
            default:
                state_next = S_IDLE;
        endcase
    end

    // outputs
    always_comb
    begin
        cmd  = '0;
        busy = (state_reg != S_IDLE);
        case (state_reg)
            S_IDLE:
                cmd.latch = start;
            S_CHECK:
            begin
                cmd.scan_clr = 1'b1;
                cmd.len_rd   = 1'b1;
            end
            S_OPEN:
                cmd.open_page = 1'b1;
            S_SCAN:
                cmd.scan_step = 1'b1;
            S_EVAL:
            begin
                cmd.carve_clr = st.fits;
                cmd.len_wr    = st.fits;
                cmd.next_page = !st.fits;
            end
            S_NEXTPG:
                cmd.scan_clr = 1'b1;
            S_CARVE:
                cmd.carve_step = 1'b1;
            S_FREE_RD:
                cmd.len_rd = 1'b1;
            S_FREE_WR:
            begin
                cmd.free_start = !st.len_zero;
                cmd.len_clr    = !st.len_zero;
            end
            S_FREE_CLR:
                cmd.free_step = 1'b1;
            S_DONE:
                cmd.emit_ok = 1'b1;
            S_FAIL:
                cmd.emit_fail = 1'b1;
            default:
                cmd = '0;
        endcase
    end

endmodule

[rtl/wfpa_dp.sv]
// wfpa_dp: free map, length store and run search of the worst-fit allocator
// depends on wfpa_pkg; driven by wfpa_ctrl

module wfpa_dp
    import wfpa_pkg::*;
#(
    parameter int PAGE_BYTES  = PAGE_BYTES_DEF,
    parameter int GRAIN_BYTES = GRAIN_BYTES_DEF,
    parameter int PAGES       = PAGES_DEF
)(
    input  logic              clk,
    input  logic              rst_n,
    input  cmd_t              cmd,
    output stat_t             st,
    input  logic              operation,
    input  logic [SIZE_W-1:0] request_size,
    input  logic [ADDR_W-1:0] address,
    output logic [ADDR_W-1:0] granted_address,
    output logic [STAT_W-1:0] status,
    output logic              done
);

    localparam int GRANULES = PAGE_BYTES / GRAIN_BYTES;
    localparam int GW       = (GRANULES > 1) ? $clog2(GRANULES) : 1;
    localparam int LW       = $clog2(GRANULES + 1);
    localparam int PW       = (PAGES > 1) ? $clog2(PAGES) : 1;
    localparam int CW       = $clog2(PAGES + 1);
    localparam int ENTRIES  = PAGES * GRANULES;
    localparam int EW       = (ENTRIES > 1) ? $clog2(ENTRIES) : 1;
    localparam int OFF_W    = $clog2(PAGE_BYTES);
    localparam int GB_W     = $clog2(GRAIN_BYTES);
    localparam int NW       = SIZE_W + 1;

    // request registers
    logic             op_reg;
    logic [NW-1:0]    need_reg;
    logic             bad_size_reg;
    logic [ADDR_W-1:0] addr_reg;

    // page and scan registers
    logic [PW-1:0]    pg_reg, pg_next;
    logic             pg_end_reg;
    logic             opened_reg;
    logic [CW-1:0]    used_reg;
    logic [GW-1:0]    g_reg;
    logic [LW-1:0]    run_reg, best_len_reg;
    logic [GW-1:0]    run_start_reg, best_start_reg;
    logic [LW-1:0]    cnt_reg;

    // result registers
    logic [ADDR_W-1:0] gaddr_reg;
    logic [STAT_W-1:0] stat_reg;
    logic              done_reg;

    // storage
    logic [GRANULES-1:0] free_map_reg [PAGES];
    logic [LW-1:0]       len_mem [ENTRIES];
    logic [ENTRIES-1:0]  len_vld_reg;
    logic [LW-1:0]       len_rd_reg;
    logic                len_rd_vld_reg;

    // size check and granule count
    logic [NW-1:0]    need_in;
    logic             bad_in;
    always_comb
    begin
        need_in = NW'(request_size >> GB_W);
        bad_in  = (request_size == '0) ||
                  (request_size[GB_W-1:0] != '0);
    end

    // free address decode
    logic [PW-1:0]  f_pg;
    logic [GW-1:0]  f_g;
    logic           f_bad;
    logic [EW-1:0]  f_idx;
    logic [ADDR_W:0] f_pg_full;
    always_comb
    begin
        f_pg_full = (ADDR_W+1)'(addr_reg >> OFF_W);
        f_pg      = PW'(f_pg_full);
        f_g       = GW'(addr_reg[OFF_W-1:0] >> GB_W);
        f_bad     = (f_pg_full >= (ADDR_W+1)'(used_reg)) ||
                    (addr_reg[GB_W-1:0] != '0);
        f_idx     = EW'(f_pg) * EW'(GRANULES) + EW'(f_g);
    end

    // carve and free index
    logic [EW-1:0] c_idx;
    logic [GW-1:0] cur_g;
    assign c_idx = EW'(pg_reg) * EW'(GRANULES) + EW'(best_start_reg);
    assign cur_g = g_reg;

    // current page granule bit
    logic cur_free;
    logic [LW-1:0] run_inc;
    assign cur_free = free_map_reg[pg_reg][cur_g];
    assign run_inc  = run_reg + LW'(1);

    // status toward controller; a page opened by this request is the last try
    always_comb
    begin
        st.is_free     = op_reg;
        st.bad_size    = bad_size_reg;
        st.pg_open     = (CW'(pg_reg) < used_reg) && !pg_end_reg;
        st.pg_can_open = (used_reg < CW'(PAGES)) && !pg_end_reg && !opened_reg;
        st.scan_last   = (g_reg == GW'(GRANULES - 1));
        st.fits        = (best_len_reg != '0) &&
                         ((NW+LW)'(best_len_reg) >= (NW+LW)'(need_reg));
        st.carve_last  = (cnt_reg == LW'(1));
        st.free_bad    = f_bad;
        st.len_zero    = !len_rd_vld_reg || (len_rd_reg == '0);
        st.free_last   = (cnt_reg == LW'(1)) || (g_reg == GW'(GRANULES - 1));
    end

    // page advance
    always_comb
    begin
        pg_next = pg_reg + PW'(1);
    end

    // request capture, page search, run search
    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            op_reg         <= 1'b0;
            need_reg       <= '0;
            bad_size_reg   <= 1'b0;
            addr_reg       <= '0;
            pg_reg         <= '0;
            pg_end_reg     <= 1'b0;
            opened_reg     <= 1'b0;
            used_reg       <= '0;
            g_reg          <= '0;
            run_reg        <= '0;
            best_len_reg   <= '0;
            run_start_reg  <= '0;
            best_start_reg <= '0;
            cnt_reg        <= '0;
        end
        else
        begin
            if (cmd.latch)
            begin
                op_reg       <= operation;
                need_reg     <= need_in;
                bad_size_reg <= bad_in;
                addr_reg     <= address;
                pg_reg       <= '0;
                pg_end_reg   <= 1'b0;
                opened_reg   <= 1'b0;
            end
            if (cmd.open_page)
            begin
                used_reg   <= used_reg + CW'(1);
                opened_reg <= 1'b1;
            end
            if (cmd.scan_clr)
            begin
                g_reg        <= '0;
                run_reg      <= '0;
                best_len_reg <= '0;
            end
            if (cmd.scan_step)
            begin
                if (!st.scan_last)
                    g_reg <= g_reg + GW'(1);
                if (cur_free)
                begin
                    run_reg <= run_inc;
                    if (run_reg == '0)
                        run_start_reg <= g_reg;
                    if (run_inc > best_len_reg)
                    begin
                        best_len_reg   <= run_inc;
                        best_start_reg <= (run_reg == '0) ? g_reg : run_start_reg;
                    end
                end
                else
                    run_reg <= '0;
            end
            if (cmd.next_page)
            begin
                if (CW'(pg_reg) == CW'(PAGES - 1))
                    pg_end_reg <= 1'b1;
                else
                    pg_reg <= pg_next;
            end
            if (cmd.carve_clr)
            begin
                g_reg   <= best_start_reg;
                cnt_reg <= LW'(need_reg);
            end
            if (cmd.carve_step)
            begin
                g_reg   <= g_reg + GW'(1);
                cnt_reg <= cnt_reg - LW'(1);
            end
            if (cmd.free_start)
            begin
                pg_reg  <= f_pg;
                g_reg   <= f_g;
                cnt_reg <= len_rd_reg;
            end
            if (cmd.free_step)
            begin
                g_reg   <= g_reg + GW'(1);
                cnt_reg <= cnt_reg - LW'(1);
            end
        end
    end

    // free map updates, one granule a cycle except a page open
    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            for (int p = 0; p < PAGES; p++)
                free_map_reg[p] <= '0;
        end
        else
        begin
            if (cmd.open_page)
                free_map_reg[PW'(used_reg)] <= '1;
            if (cmd.carve_step)
                free_map_reg[pg_reg][cur_g] <= 1'b0;
            if (cmd.free_step)
                free_map_reg[pg_reg][cur_g] <= 1'b1;
        end
    end

    // length store valid bits
    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
            len_vld_reg <= '0;
        else if (cmd.len_wr)
            len_vld_reg[c_idx] <= 1'b1;
        else if (cmd.len_clr)
            len_vld_reg[f_idx] <= 1'b0;
    end

    // length store memory
    always_ff @(posedge clk)
    begin
        if (cmd.len_wr)
            len_mem[c_idx] <= LW'(need_reg);
        if (cmd.len_rd)
        begin
            len_rd_reg     <= len_mem[f_idx];
            len_rd_vld_reg <= len_vld_reg[f_idx];
        end
    end

    // result registers
    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            done_reg  <= 1'b0;
            gaddr_reg <= '0;
            stat_reg  <= '0;
        end
        else
        begin
            done_reg <= cmd.emit_ok || cmd.emit_fail;
            if (cmd.emit_ok)
            begin
                stat_reg  <= ST_OK;
                gaddr_reg <= op_reg ? '0 :
                    ADDR_W'(pg_reg) * ADDR_W'(PAGE_BYTES) +
                    ADDR_W'(best_start_reg) * ADDR_W'(GRAIN_BYTES);
            end
            else if (cmd.emit_fail)
            begin
                gaddr_reg <= '0;
                if (op_reg)
                    stat_reg <= ST_BADFREE;
                else if (bad_size_reg)
                    stat_reg <= ST_BADSIZE;
                else
                    stat_reg <= ST_NOSPACE;
            end
        end
    end

    assign granted_address = gaddr_reg;
    assign status          = stat_reg;
    assign done            = done_reg;

endmodule

[rtl/worst_fit_paged_allocator.sv]
// Worst-fit paged allocator.
// A request is taken when start is high and busy is low: operation 0
// allocates request_size bytes, operation 1 frees the allocation that begins
// at address. Exactly one transaction comes back per request on
// granted_address and status, marked by done for one cycle; the receiver
// cannot stall it.
// An allocation scans each page it visits one granule per cycle to find its
// largest free run, then clears the carved granules one per cycle. By
// default there are four pages of sixteen granules. A free releases the
// granules of its allocation. A bad size, or a free address off an open
// page or off a granule boundary, fails without a scan; a free of a granule
// that starts no allocation fails as well.
// busy falls in the cycle done is shown, so the next request may be taken
// while the previous result is out; one request is in work at a time.
// Reset clears the free map, the length store valid bits and the page
// count; no clearing pass is needed afterwards.
// depends on wfpa_pkg, wfpa_ctrl and wfpa_dp

module worst_fit_paged_allocator
    import wfpa_pkg::*;
#(
    parameter int PAGE_BYTES  = PAGE_BYTES_DEF,
    parameter int GRAIN_BYTES = GRAIN_BYTES_DEF,
    parameter int PAGES       = PAGES_DEF
)(
    input  logic              clk,
    input  logic              rst_n,
    input  logic              start,
    output logic              busy,
    input  logic              operation,
    input  logic [SIZE_W-1:0] request_size,
    input  logic [ADDR_W-1:0] address,
    output logic              done,
    output logic [ADDR_W-1:0] granted_address,
    output logic [STAT_W-1:0] status
);

    cmd_t  cmd;
    stat_t st;

    wfpa_ctrl u_ctrl (
        .clk   (clk),
        .rst_n (rst_n),
        .start (start),
        .busy  (busy),
        .cmd   (cmd),
        .st    (st)
    );

    wfpa_dp #(
        .PAGE_BYTES  (PAGE_BYTES),
        .GRAIN_BYTES (GRAIN_BYTES),
        .PAGES       (PAGES)
    ) u_dp (
        .clk             (clk),
        .rst_n           (rst_n),
        .cmd             (cmd),
        .st              (st),
        .operation       (operation),
        .request_size    (request_size),
        .address         (address),
        .granted_address (granted_address),
        .status          (status),
        .done            (done)
    );

`ifndef ASSERT_OFF
    // a failed transaction never carries an address
    a_fail_zero: assert property (@(posedge clk) disable iff (!rst_n)
        done && status != ST_OK |-> granted_address == '0)
        else $error("failed transaction carries an address");

    // a result only ends a request that was in work
    a_done_busy: assert property (@(posedge clk) disable iff (!rst_n)
        done |-> $past(busy))
        else $error("result without a request in work");

    // carve and release never happen together
    a_excl: assert property (@(posedge clk) disable iff (!rst_n)
        !(cmd.carve_step && cmd.free_step))
        else $error("carve and release overlap");
`endif

endmodule
